@@ hw/rtl/pqem_pkg.sv @@
// ----------------------------------------------------------------------------
// pqem_pkg: shared constants for the extract-max priority queue
// Field widths of the item channels, operation codes and parameter defaults.
// ----------------------------------------------------------------------------
package pqem_pkg;

  // Fixed widths of the channel fields
  localparam int unsigned OP_W    = 2;
  localparam int unsigned ITEM_W  = 16;
  localparam int unsigned PRIO_W  = 8;
  localparam int unsigned TOTAL_W = 5;

  // Defaults for the top-level parameters
  localparam int unsigned DEPTH_DEF     = 16;
  localparam int unsigned ITEM_BITS_DEF = 16;
  localparam int unsigned PRIO_BITS_DEF = 8;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ADD     = 2'd0;
  localparam logic [OP_W-1:0] OP_EXTRACT = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

endpackage

@@ hw/rtl/pqem_if.sv @@
// ----------------------------------------------------------------------------
// pqem_if: item channels of the extract-max priority queue
// Request channel (operation and pair) and result channel (item and status).
// ----------------------------------------------------------------------------
interface pqem_in_if;
  logic                          valid;
  logic                          ready;
  logic [pqem_pkg::OP_W-1:0]     operation;
  logic [pqem_pkg::ITEM_W-1:0]   item_value;
  logic [pqem_pkg::PRIO_W-1:0]   priority_value;

  modport source (output valid, operation, item_value, priority_value, input ready);
  modport sink   (input valid, operation, item_value, priority_value, output ready);
endinterface

interface pqem_out_if;
  logic                          valid;
  logic                          ready;
  logic [pqem_pkg::ITEM_W-1:0]   out_item;
  logic                          out_valid;
  logic                          add_dropped;
  logic [pqem_pkg::TOTAL_W-1:0]  entry_total;
  logic                          queue_empty;
  logic                          queue_full;

  modport source (output valid, out_item, out_valid, add_dropped, entry_total,
                  queue_empty, queue_full, input ready);
  modport sink   (input valid, out_item, out_valid, add_dropped, entry_total,
                  queue_empty, queue_full, output ready);
endinterface

@@ hw/rtl/pqem_ram.sv @@
// ----------------------------------------------------------------------------
// pqem_ram: generic simple dual-port RAM
// One write port and one read port per cycle, read data registered.
// ----------------------------------------------------------------------------
module pqem_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/priority_queue_extract_max.sv @@
// ----------------------------------------------------------------------------
// priority_queue_extract_max: bounded priority queue with extract-max
// Unsorted store of (item, priority) pairs in arrival order, held in one RAM.
// Extract scans the store for the highest priority (earliest wins ties) and
// then shifts the later entries down by one, both through the RAM ports.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake       | payload
//  --------+-----+-----------------+-------------------------------------------
//  in_i    | in  | valid / ready   | operation, item_value, priority_value
//  out_o   | out | valid / ready   | out_item, out_valid, add_dropped,
//          |     |                 | entry_total, queue_empty, queue_full
//
// Add, clear and no-op pass from accept through the RESP state to the output register.
// Extract scans the held entries with one RAM read a cycle, then shifts the entries
// after the winning index down with one read and one write a cycle, and then goes
// through RESP to the output register. One item is in work at a time.
// Reset clears the count and the sequencer; no clearing pass is run.
// A stalled output holds its result; the next item is still accepted meanwhile.
// ----------------------------------------------------------------------------
module priority_queue_extract_max #(
  parameter int unsigned DEPTH         = pqem_pkg::DEPTH_DEF,
  parameter int unsigned ITEM_BITS     = pqem_pkg::ITEM_BITS_DEF,
  parameter int unsigned PRIORITY_BITS = pqem_pkg::PRIO_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pqem_in_if.sink     in_i,
  pqem_out_if.source  out_o
);
  import pqem_pkg::*;

  localparam int unsigned IDX_W   = $clog2(DEPTH);
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned ENTRY_W = ITEM_BITS + PRIORITY_BITS;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_SHIFT = 2'd2;
  localparam logic [1:0] ST_RESP  = 2'd3;

  logic [1:0]               st_q, st_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic [IDX_W-1:0]         scan_idx_q, scan_idx_d;
  logic [IDX_W-1:0]         wr_idx_q, wr_idx_d;
  logic [IDX_W-1:0]         best_idx_q, best_idx_d;
  logic [PRIORITY_BITS-1:0] best_prio_q, best_prio_d;
  logic [ITEM_BITS-1:0]     best_item_q, best_item_d;
  logic [ITEM_BITS-1:0]     res_item_q, res_item_d;
  logic                     res_hit_q, res_hit_d;
  logic                     res_drop_q, res_drop_d;

  logic                     ov_q;
  logic [ITEM_W-1:0]        out_item_q;
  logic                     out_hit_q;
  logic                     out_drop_q;
  logic [TOTAL_W-1:0]       out_total_q;
  logic                     out_empty_q;
  logic                     out_full_q;

  logic                     ram_we;
  logic [IDX_W-1:0]         ram_waddr;
  logic [ENTRY_W-1:0]       ram_wdata;
  logic                     ram_re;
  logic [IDX_W-1:0]         ram_raddr;
  logic [ENTRY_W-1:0]       ram_rdata;

  logic                     in_acc;
  logic                     out_acc;
  logic                     out_load;
  logic [IDX_W-1:0]         cnt_m1;
  logic [PRIORITY_BITS-1:0] rd_prio;
  logic [ITEM_BITS-1:0]     rd_item;
  logic                     take;
  logic [IDX_W-1:0]         best_idx_nx;
  logic [PRIORITY_BITS-1:0] best_prio_nx;
  logic [ITEM_BITS-1:0]     best_item_nx;

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_acc  = ov_q && out_o.ready;
  assign out_load = (st_q == ST_RESP) && (!ov_q || out_o.ready);

  assign cnt_m1  = IDX_W'(cnt_q - CNT_W'(1));
  assign rd_prio = ram_rdata[ENTRY_W-1 -: PRIORITY_BITS];
  assign rd_item = ram_rdata[ITEM_BITS-1:0];

  // Compare the entry just read against the best so far; first entry seeds it
  assign take         = (scan_idx_q == '0) || (rd_prio > best_prio_q);
  assign best_idx_nx  = take ? scan_idx_q : best_idx_q;
  assign best_prio_nx = take ? rd_prio    : best_prio_q;
  assign best_item_nx = take ? rd_item    : best_item_q;

  // Entry store
  pqem_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Sequencer
  always_comb begin
    st_d        = st_q;
    cnt_d       = cnt_q;
    scan_idx_d  = scan_idx_q;
    wr_idx_d    = wr_idx_q;
    best_idx_d  = best_idx_q;
    best_prio_d = best_prio_q;
    best_item_d = best_item_q;
    res_item_d  = res_item_q;
    res_hit_d   = res_hit_q;
    res_drop_d  = res_drop_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = {PRIORITY_BITS'(in_i.priority_value), ITEM_BITS'(in_i.item_value)};
    ram_re      = 1'b0;
    ram_raddr   = '0;

    unique case (st_q)
      ST_IDLE: begin
        if (in_acc) begin
          res_item_d = '0;
          res_hit_d  = 1'b0;
          res_drop_d = 1'b0;
          st_d       = ST_RESP;
          unique case (in_i.operation)
            OP_ADD: begin
              // Append when there is room, else drop
              if (cnt_q < CNT_W'(DEPTH)) begin
                ram_we    = 1'b1;
                ram_waddr = IDX_W'(cnt_q);
                cnt_d     = cnt_q + CNT_W'(1);
              end else begin
                res_drop_d = 1'b1;
              end
            end
            OP_EXTRACT: begin
              // Start the scan at entry zero
              if (cnt_q != '0) begin
                ram_re     = 1'b1;
                ram_raddr  = '0;
                scan_idx_d = '0;
                st_d       = ST_SCAN;
              end
            end
            OP_CLEAR: begin
              cnt_d = '0;
            end
            default: begin
            end
          endcase
        end
      end

      ST_SCAN: begin
        best_idx_d  = best_idx_nx;
        best_prio_d = best_prio_nx;
        best_item_d = best_item_nx;
        if (scan_idx_q != cnt_m1) begin
          // Fetch the next entry
          ram_re     = 1'b1;
          ram_raddr  = scan_idx_q + IDX_W'(1);
          scan_idx_d = scan_idx_q + IDX_W'(1);
        end else begin
          res_item_d = best_item_nx;
          res_hit_d  = 1'b1;
          if (best_idx_nx == cnt_m1) begin
            // Winner is the last entry: nothing to shift
            cnt_d = cnt_q - CNT_W'(1);
            st_d  = ST_RESP;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = best_idx_nx + IDX_W'(1);
            wr_idx_d  = best_idx_nx;
            st_d      = ST_SHIFT;
          end
        end
      end

      ST_SHIFT: begin
        // Move entry wr_idx + 1 down into wr_idx
        ram_we    = 1'b1;
        ram_waddr = wr_idx_q;
        ram_wdata = ram_rdata;
        if ((wr_idx_q + IDX_W'(1)) != cnt_m1) begin
          ram_re    = 1'b1;
          ram_raddr = wr_idx_q + IDX_W'(2);
          wr_idx_d  = wr_idx_q + IDX_W'(1);
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
          st_d  = ST_RESP;
        end
      end

      ST_RESP: begin
        if (out_load) begin
          st_d = ST_IDLE;
        end
      end

      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_IDLE;
      cnt_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
      if (out_load) begin
        ov_q <= 1'b1;
      end else if (out_acc) begin
        ov_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    scan_idx_q  <= scan_idx_d;
    wr_idx_q    <= wr_idx_d;
    best_idx_q  <= best_idx_d;
    best_prio_q <= best_prio_d;
    best_item_q <= best_item_d;
    res_item_q  <= res_item_d;
    res_hit_q   <= res_hit_d;
    res_drop_q  <= res_drop_d;
  end

  // Output register: load the finished result with the status after the operation
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_item_q  <= ITEM_W'(res_item_q);
      out_hit_q   <= res_hit_q;
      out_drop_q  <= res_drop_q;
      out_total_q <= TOTAL_W'(cnt_q);
      out_empty_q <= (cnt_q == '0);
      out_full_q  <= (cnt_q == CNT_W'(DEPTH));
    end
  end

  assign in_i.ready        = (st_q == ST_IDLE);
  assign out_o.valid       = ov_q;
  assign out_o.out_item    = out_item_q;
  assign out_o.out_valid   = out_hit_q;
  assign out_o.add_dropped = out_drop_q;
  assign out_o.entry_total = out_total_q;
  assign out_o.queue_empty = out_empty_q;
  assign out_o.queue_full  = out_full_q;

  // Count never exceeds the depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  // Scan only runs on a non-empty store
  a_scan_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_SCAN) |-> (cnt_q != '0))
    else $error("scan with empty store");

  // Extract on a non-empty store starts a scan
  a_extract_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_i.operation == OP_EXTRACT) && (cnt_q != '0)) |=> (st_q == ST_SCAN))
    else $error("extract did not start a scan");

  // Shift writes stay below the last held entry
  a_shift_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_SHIFT) |-> (wr_idx_q < cnt_m1))
    else $error("shift index out of range");

endmodule

@@ verif/priority_queue_extract_max_tb.sv @@
// ----------------------------------------------------------------------------
// priority_queue_extract_max_tb: self-checking bench for the extract-max queue
// Drives add, extract, clear and no-op items through the request channel and
// checks every result against a shadow queue kept inside the bench. It covers
// directed corners first, then random mixes, fill and drain runs and
// back-to-back stretches, with random gaps on both channels.
// ----------------------------------------------------------------------------
module priority_queue_extract_max_tb;
  import pqem_pkg::*;

  localparam int unsigned QUEUE_DEPTH   = DEPTH_DEF;
  localparam logic [OP_W-1:0] OP_NOP    = 2'd3;
  localparam int unsigned DRAIN_CYCLES  = 2 * QUEUE_DEPTH + 8;
  localparam int unsigned TIMEOUT_UNITS = 5_000_000;

  typedef struct packed {
    logic [ITEM_W-1:0]  item;
    logic               out_valid;
    logic               dropped;
    logic [TOTAL_W-1:0] total;
    logic               empty;
    logic               full;
  } queue_result_t;

  logic clk_i;
  logic rst_ni;

  pqem_in_if  in_ch ();
  pqem_out_if out_ch ();

  priority_queue_extract_max i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // Shadow copy of the queue contents
  logic [ITEM_W-1:0] shadow_items [QUEUE_DEPTH];
  logic [PRIO_W-1:0] shadow_prios [QUEUE_DEPTH];
  int unsigned       shadow_count;

  queue_result_t pending_results [$];
  queue_result_t want_res;

  bit          throttle_on = 1'b1;
  int unsigned stall_left  = 0;
  int unsigned fail_count  = 0;
  int unsigned n_sent      = 0;
  int unsigned n_checked   = 0;
  int unsigned n_dropped   = 0;
  int unsigned n_extracted = 0;
  int unsigned n_full_seen = 0;

  // Clock: period 10
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Gap length: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    else if (r < 92) return $urandom_range(1, 3);
    else return $urandom_range(6, 40);
  endfunction

  // Advance the shadow queue by one item and record the result it must give
  task automatic apply_queue_op(input logic [OP_W-1:0] op, input logic [ITEM_W-1:0] item,
                                input logic [PRIO_W-1:0] prio);
    queue_result_t res;
    int unsigned   best;
    res = '0;
    case (op)
      OP_ADD: begin
        if (shadow_count < QUEUE_DEPTH) begin
          shadow_items[shadow_count] = item;
          shadow_prios[shadow_count] = prio;
          shadow_count++;
        end else begin
          res.dropped = 1'b1;
          n_dropped++;
        end
      end
      OP_EXTRACT: begin
        if (shadow_count > 0) begin
          // Earliest entry wins ties: only a strictly larger priority moves best
          best = 0;
          for (int unsigned i = 1; i < shadow_count; i++) begin
            if (shadow_prios[i] > shadow_prios[best]) best = i;
          end
          res.item      = shadow_items[best];
          res.out_valid = 1'b1;
          for (int unsigned i = best; i + 1 < shadow_count; i++) begin
            shadow_items[i] = shadow_items[i + 1];
            shadow_prios[i] = shadow_prios[i + 1];
          end
          shadow_count--;
          n_extracted++;
        end
      end
      OP_CLEAR: shadow_count = 0;
      default: ;
    endcase
    res.total = TOTAL_W'(shadow_count);
    res.empty = (shadow_count == 0);
    res.full  = (shadow_count == QUEUE_DEPTH);
    if (res.full) n_full_seen++;
    pending_results.push_back(res);
  endtask

  // Send one item and wait for the handshake
  task automatic send_item(input logic [OP_W-1:0] op, input logic [ITEM_W-1:0] item,
                           input logic [PRIO_W-1:0] prio);
    int unsigned gap;
    @(negedge clk_i);
    in_ch.valid          <= 1'b1;
    in_ch.operation      <= op;
    in_ch.item_value     <= item;
    in_ch.priority_value <= prio;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    apply_queue_op(op, item, prio);
    n_sent++;
    gap = throttle_on ? pick_gap() : 0;
    repeat (gap) begin
      @(negedge clk_i);
      in_ch.valid <= 1'b0;
    end
  endtask

  // Hold the sender until every expected result has come back
  task automatic wait_drained();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Random item with a weighted operation and tie-prone priorities
  task automatic send_random_item();
    int unsigned       r;
    logic [OP_W-1:0]   op;
    logic [PRIO_W-1:0] prio;
    r = $urandom_range(0, 99);
    if (r < 50) op = OP_ADD;
    else if (r < 85) op = OP_EXTRACT;
    else if (r < 92) op = OP_CLEAR;
    else op = OP_NOP;
    prio = $urandom_range(0, 1) ? PRIO_W'($urandom_range(0, 255))
                                : PRIO_W'($urandom_range(252, 255));
    send_item(op, ITEM_W'($urandom()), prio);
  endtask

  // Extract and clear on an empty queue, and the unused operation code
  task automatic test_empty_queue();
    send_item(OP_EXTRACT, 16'hFFFF, 8'hFF);
    send_item(OP_NOP, 16'hFFFF, 8'hFF);
    send_item(OP_CLEAR, 16'h0000, 8'h00);
  endtask

  // Fill to full with extreme values and ties, overflow, drain a few, clear
  task automatic test_full_queue();
    send_item(OP_ADD, 16'h0000, 8'h00);
    send_item(OP_ADD, 16'hFFFF, 8'hFF);
    send_item(OP_ADD, 16'h1111, 8'h80);
    send_item(OP_ADD, 16'h2222, 8'hFF);
    for (int unsigned i = 4; i < QUEUE_DEPTH; i++) begin
      send_item(OP_ADD, ITEM_W'(i * 16'h0505), PRIO_W'(i * 7));
    end
    send_item(OP_ADD, 16'hBEEF, 8'hFF);
    repeat (4) send_item(OP_EXTRACT, 16'h0000, 8'h00);
    send_item(OP_CLEAR, 16'h0000, 8'h00);
  endtask

  // Random mix of all operations
  task automatic test_random_mix(input int unsigned count);
    repeat (count) send_random_item();
  endtask

  // Fill and drain runs that reach full and empty, with some noise between
  task automatic test_fill_drain();
    int unsigned n_add;
    int unsigned n_ext;
    repeat (8) begin
      n_add = $urandom_range(10, 20);
      n_ext = $urandom_range(8, 18);
      repeat (n_add) begin
        send_item(OP_ADD, ITEM_W'($urandom()),
                  $urandom_range(0, 1) ? PRIO_W'($urandom()) : PRIO_W'($urandom_range(0, 3)));
      end
      repeat (n_ext) send_item(OP_EXTRACT, ITEM_W'($urandom()), PRIO_W'($urandom()));
      repeat ($urandom_range(0, 2)) send_random_item();
    end
  endtask

  // Pause the sender until the queue results are all back, then extract
  task automatic test_drained_pause();
    repeat (4) begin
      repeat (5) send_item(OP_ADD, ITEM_W'($urandom()), PRIO_W'($urandom()));
      wait_drained();
      repeat (6) send_item(OP_EXTRACT, ITEM_W'($urandom()), PRIO_W'($urandom()));
      wait_drained();
    end
  endtask

  // Back-to-back items with no gaps on either side
  task automatic test_back_to_back(input int unsigned count);
    throttle_on = 1'b0;
    repeat (count) send_random_item();
    throttle_on = 1'b1;
  endtask

  // Drive the result ready with random stalls
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if (throttle_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result arrived with no expectation pending", $time);
        fail_count++;
      end else begin
        want_res = pending_results.pop_front();
        check_field("out_item", 32'(want_res.item), 32'(out_ch.out_item));
        check_field("out_valid", 32'(want_res.out_valid), 32'(out_ch.out_valid));
        check_field("add_dropped", 32'(want_res.dropped), 32'(out_ch.add_dropped));
        check_field("entry_total", 32'(want_res.total), 32'(out_ch.entry_total));
        check_field("queue_empty", 32'(want_res.empty), 32'(out_ch.queue_empty));
        check_field("queue_full", 32'(want_res.full), 32'(out_ch.queue_full));
        n_checked++;
      end
    end
  end

  // Main sequence
  initial begin
    rst_ni               = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.operation      = OP_ADD;
    in_ch.item_value     = '0;
    in_ch.priority_value = '0;
    shadow_count         = 0;
    for (int unsigned i = 0; i < QUEUE_DEPTH; i++) begin
      shadow_items[i] = '0;
      shadow_prios[i] = '0;
    end
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_queue();
    test_full_queue();
    test_random_mix(300);
    test_fill_drain();
    test_drained_pause();
    test_back_to_back(120);
    wait_drained();

    $display("Sent %0d items, checked %0d results: %0d extracted, %0d adds dropped,",
             n_sent, n_checked, n_extracted, n_dropped);
    $display("full queue reached %0d times, with random gaps on both channels.", n_full_seen);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Give up after a generous fixed time
  initial begin
    #(TIMEOUT_UNITS);
    $display("Timeout with %0d results still pending", pending_results.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/pqem_pkg.sv
hw/rtl/pqem_if.sv
hw/rtl/pqem_ram.sv
hw/rtl/priority_queue_extract_max.sv
verif/priority_queue_extract_max_tb.sv
